@@ rtl/stc_pkg.sv @@
package stc_pkg;

    // default coordinate width, signed Q10.6
    localparam int COORD_WIDTH_DEF = 16;

    // counts of the values carried between stages
    localparam int N_COORD = 10;
    localparam int N_DIFF  = 23;
    localparam int N_PROD  = 28;
    localparam int N_SUM   = 14;
    localparam int N_EDGE  = 3;
    localparam int N_PT    = 2;

    // result codes
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_CROSS  = 2'd1;
    localparam logic [1:0] KIND_INSIDE = 2'd2;

    // coordinate order: ax ay bx by cx cy dx dy ex ey
    // differences: segment direction, per edge (dir x, dir y, offset x, offset y),
    // then the barycentric terms bcy cbx cay acx acy and d, e relative to c
    localparam int DIFF_P [N_DIFF] = '{8, 9,
                                       2, 3, 6, 7,
                                       4, 5, 6, 7,
                                       0, 1, 6, 7,
                                       3, 4, 5, 0, 1, 6, 7, 8, 9};
    localparam int DIFF_Q [N_DIFF] = '{6, 7,
                                       0, 1, 0, 1,
                                       2, 3, 2, 3,
                                       4, 5, 4, 5,
                                       5, 2, 1, 4, 5, 4, 5, 4, 5};

    // product operand pairs, six per edge then the triangle and point terms
    localparam int PROD_A [N_PROD] = '{3, 2, 2, 3, 0, 1,
                                       7, 6, 6, 7, 0, 1,
                                       11, 10, 10, 11, 0, 1,
                                       14, 15,
                                       14, 15, 16, 17,
                                       14, 15, 16, 17};
    localparam int PROD_B [N_PROD] = '{0, 1, 5, 4, 5, 4,
                                       0, 1, 9, 8, 9, 8,
                                       0, 1, 13, 12, 13, 12,
                                       17, 18,
                                       19, 20, 19, 20,
                                       21, 22, 21, 22};

    // sum terms: edge den/na/nb, triangle den, then n1/n2 for d and e
    localparam int SUM_P [N_SUM] = '{0, 2, 4, 6, 8, 10, 12, 14, 16, 18, 20, 22, 24, 26};
    localparam int SUM_Q [N_SUM] = '{1, 3, 5, 7, 9, 11, 13, 15, 17, 19, 21, 23, 25, 27};
    localparam logic SUM_SUB [N_SUM] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                         1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    localparam int SUM_TRI_DEN = 9;
    localparam int SUM_PT_BASE = 10;

endpackage

@@ rtl/stc_in_if.sv @@
interface stc_in_if #(
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] tri_a_x;
    logic signed [COORD_WIDTH-1:0] tri_a_y;
    logic signed [COORD_WIDTH-1:0] tri_b_x;
    logic signed [COORD_WIDTH-1:0] tri_b_y;
    logic signed [COORD_WIDTH-1:0] tri_c_x;
    logic signed [COORD_WIDTH-1:0] tri_c_y;
    logic signed [COORD_WIDTH-1:0] seg_d_x;
    logic signed [COORD_WIDTH-1:0] seg_d_y;
    logic signed [COORD_WIDTH-1:0] seg_e_x;
    logic signed [COORD_WIDTH-1:0] seg_e_y;

    modport source (
        output valid, tri_a_x, tri_a_y, tri_b_x, tri_b_y, tri_c_x, tri_c_y,
               seg_d_x, seg_d_y, seg_e_x, seg_e_y,
        input  ready
    );

    modport sink (
        input  valid, tri_a_x, tri_a_y, tri_b_x, tri_b_y, tri_c_x, tri_c_y,
               seg_d_x, seg_d_y, seg_e_x, seg_e_y,
        output ready
    );
endinterface

@@ rtl/stc_out_if.sv @@
interface stc_out_if;
    logic       valid;
    logic       ready;
    logic       touches;
    logic [1:0] hit_kind;

    modport source (
        output valid, touches, hit_kind,
        input  ready
    );

    modport sink (
        input  valid, touches, hit_kind,
        output ready
    );
endinterface

@@ rtl/stc_diff.sv @@
module stc_diff #(
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    output logic                          in_rdy,
    input  logic signed [COORD_WIDTH-1:0] coord [stc_pkg::N_COORD],
    output logic                          out_vld,
    input  logic                          out_rdy,
    output logic signed [COORD_WIDTH:0]   diff [stc_pkg::N_DIFF]
);

    logic                        vld_reg;
    logic signed [COORD_WIDTH:0] diff_reg  [stc_pkg::N_DIFF];
    logic signed [COORD_WIDTH:0] diff_next [stc_pkg::N_DIFF];

    // stage moves when empty or when the next stage takes its item
    assign in_rdy = !vld_reg || out_rdy;

    // coordinate differences, one bit wider than the inputs
    always_comb
    begin
        for (int i = 0; i < stc_pkg::N_DIFF; i++)
        begin
            diff_next[i] = (COORD_WIDTH+1)'(coord[stc_pkg::DIFF_P[i]])
                         - (COORD_WIDTH+1)'(coord[stc_pkg::DIFF_Q[i]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_vld)
        begin
            diff_reg <= diff_next;
        end
    end

    assign out_vld = vld_reg;
    assign diff    = diff_reg;

endmodule

@@ rtl/stc_mult.sv @@
module stc_mult #(
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    output logic                              in_rdy,
    input  logic signed [COORD_WIDTH:0]       diff [stc_pkg::N_DIFF],
    output logic                              out_vld,
    input  logic                              out_rdy,
    output logic signed [2*COORD_WIDTH+1:0]   prod [stc_pkg::N_PROD]
);

    logic                            vld_reg;
    logic signed [2*COORD_WIDTH+1:0] prod_reg  [stc_pkg::N_PROD];
    logic signed [2*COORD_WIDTH+1:0] prod_next [stc_pkg::N_PROD];

    assign in_rdy = !vld_reg || out_rdy;

    // one independent multiplier per product term
    always_comb
    begin
        for (int i = 0; i < stc_pkg::N_PROD; i++)
        begin
            prod_next[i] = diff[stc_pkg::PROD_A[i]] * diff[stc_pkg::PROD_B[i]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_vld)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_vld = vld_reg;
    assign prod    = prod_reg;

endmodule

@@ rtl/stc_sum.sv @@
module stc_sum #(
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_vld,
    output logic                            in_rdy,
    input  logic signed [2*COORD_WIDTH+1:0] prod [stc_pkg::N_PROD],
    output logic                            out_vld,
    input  logic                            out_rdy,
    output logic signed [2*COORD_WIDTH+2:0] sum [stc_pkg::N_SUM]
);

    localparam int SW = 2*COORD_WIDTH + 3;

    logic                 vld_reg;
    logic signed [SW-1:0] sum_reg  [stc_pkg::N_SUM];
    logic signed [SW-1:0] sum_next [stc_pkg::N_SUM];

    assign in_rdy = !vld_reg || out_rdy;

    // cross products and barycentric numerators from product pairs
    always_comb
    begin
        for (int i = 0; i < stc_pkg::N_SUM; i++)
        begin
            if (stc_pkg::SUM_SUB[i])
            begin
                sum_next[i] = SW'(prod[stc_pkg::SUM_P[i]]) - SW'(prod[stc_pkg::SUM_Q[i]]);
            end
            else
            begin
                sum_next[i] = SW'(prod[stc_pkg::SUM_P[i]]) + SW'(prod[stc_pkg::SUM_Q[i]]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_vld)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_vld = vld_reg;
    assign sum     = sum_reg;

endmodule

@@ rtl/stc_decide.sv @@
module stc_decide #(
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_vld,
    output logic                            in_rdy,
    input  logic signed [2*COORD_WIDTH+2:0] sum [stc_pkg::N_SUM],
    output logic                            out_vld,
    input  logic                            out_rdy,
    output logic [stc_pkg::N_EDGE-1:0]      edge_hit,
    output logic [stc_pkg::N_PT-1:0]        pt_hit
);

    localparam int SW = 2*COORD_WIDTH + 3;

    logic                       vld_reg;
    logic [stc_pkg::N_EDGE-1:0] edge_hit_reg;
    logic [stc_pkg::N_EDGE-1:0] edge_hit_next;
    logic [stc_pkg::N_PT-1:0]   pt_hit_reg;
    logic [stc_pkg::N_PT-1:0]   pt_hit_next;

    logic signed [SW-1:0] e_den [stc_pkg::N_EDGE];
    logic signed [SW-1:0] e_na  [stc_pkg::N_EDGE];
    logic signed [SW-1:0] e_nb  [stc_pkg::N_EDGE];
    logic signed [SW:0]   e_dna [stc_pkg::N_EDGE];
    logic signed [SW:0]   e_dnb [stc_pkg::N_EDGE];
    logic                 e_pos [stc_pkg::N_EDGE];
    logic                 e_neg [stc_pkg::N_EDGE];

    logic signed [SW-1:0] t_den;
    logic signed [SW-1:0] p_n1 [stc_pkg::N_PT];
    logic signed [SW-1:0] p_n2 [stc_pkg::N_PT];
    logic signed [SW+1:0] p_n3 [stc_pkg::N_PT];
    logic                 p_pos [stc_pkg::N_PT];
    logic                 p_neg [stc_pkg::N_PT];

    assign in_rdy = !vld_reg || out_rdy;

    // edge crossing: both parameters in [0,1], zero denominator never crosses
    always_comb
    begin
        for (int k = 0; k < stc_pkg::N_EDGE; k++)
        begin
            e_den[k] = sum[3*k];
            e_na[k]  = sum[3*k+1];
            e_nb[k]  = sum[3*k+2];
            e_dna[k] = (SW+1)'(e_den[k]) - (SW+1)'(e_na[k]);
            e_dnb[k] = (SW+1)'(e_den[k]) - (SW+1)'(e_nb[k]);
            // all terms share the sign of the denominator, zero allowed
            e_pos[k] = !e_na[k][SW-1] && !e_dna[k][SW] && !e_nb[k][SW-1] && !e_dnb[k][SW];
            e_neg[k] = (e_na[k][SW-1] || e_na[k] == '0)
                    && (e_dna[k][SW] || e_dna[k] == '0)
                    && (e_nb[k][SW-1] || e_nb[k] == '0)
                    && (e_dnb[k][SW] || e_dnb[k] == '0);
            if (e_den[k] == '0)
            begin
                edge_hit_next[k] = 1'b0;
            end
            else if (e_den[k][SW-1])
            begin
                edge_hit_next[k] = e_neg[k];
            end
            else
            begin
                edge_hit_next[k] = e_pos[k];
            end
        end
    end

    // point inside: three barycentric weights with the sign of the area
    assign t_den = sum[stc_pkg::SUM_TRI_DEN];

    always_comb
    begin
        for (int p = 0; p < stc_pkg::N_PT; p++)
        begin
            p_n1[p]  = sum[stc_pkg::SUM_PT_BASE + 2*p];
            p_n2[p]  = sum[stc_pkg::SUM_PT_BASE + 2*p + 1];
            p_n3[p]  = (SW+2)'(t_den) - (SW+2)'(p_n1[p]) - (SW+2)'(p_n2[p]);
            p_pos[p] = !p_n1[p][SW-1] && !p_n2[p][SW-1] && !p_n3[p][SW+1];
            p_neg[p] = (p_n1[p][SW-1] || p_n1[p] == '0)
                    && (p_n2[p][SW-1] || p_n2[p] == '0)
                    && (p_n3[p][SW+1] || p_n3[p] == '0);
            if (t_den == '0)
            begin
                pt_hit_next[p] = 1'b0;
            end
            else if (t_den[SW-1])
            begin
                pt_hit_next[p] = p_neg[p];
            end
            else
            begin
                pt_hit_next[p] = p_pos[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_vld)
        begin
            edge_hit_reg <= edge_hit_next;
            pt_hit_reg   <= pt_hit_next;
        end
    end

    assign out_vld  = vld_reg;
    assign edge_hit = edge_hit_reg;
    assign pt_hit   = pt_hit_reg;

endmodule

@@ rtl/segment_triangle_contact_test_unit.sv @@
// Segment/triangle contact test. Each query transfer carries a triangle ABC and
// a segment DE in signed fixed point; each result transfer reports whether they
// touch: hit_kind 1 when DE crosses edge AB, BC or CA (ends included, parallel
// or collinear edges never count), else 2 when D or E lies inside or on the
// triangle (a zero-area triangle contains nothing), else 0; touches is set for
// any nonzero hit_kind. Arithmetic is exact. The unit is a five-stage pipeline
// (differences, products, cross sums, sign tests, result register): it takes
// one query per cycle, and the only thing that slows it is the result side
// holding ready low, which stalls every full stage through a combinational
// ready chain while empty stages keep taking items.
module segment_triangle_contact_test_unit #(
    parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    stc_in_if.sink   query,
    stc_out_if.source result
);

    logic signed [COORD_WIDTH-1:0]   coord [stc_pkg::N_COORD];
    logic signed [COORD_WIDTH:0]     diff  [stc_pkg::N_DIFF];
    logic signed [2*COORD_WIDTH+1:0] prod  [stc_pkg::N_PROD];
    logic signed [2*COORD_WIDTH+2:0] sum   [stc_pkg::N_SUM];
    logic [stc_pkg::N_EDGE-1:0]      edge_hit;
    logic [stc_pkg::N_PT-1:0]        pt_hit;

    logic diff_vld;
    logic diff_rdy;
    logic prod_vld;
    logic prod_rdy;
    logic sum_vld;
    logic sum_rdy;
    logic flag_vld;
    logic flag_rdy;

    logic       vld_reg;
    logic       touches_reg;
    logic       touches_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;

    // query fields in model order
    assign coord[0] = query.tri_a_x;
    assign coord[1] = query.tri_a_y;
    assign coord[2] = query.tri_b_x;
    assign coord[3] = query.tri_b_y;
    assign coord[4] = query.tri_c_x;
    assign coord[5] = query.tri_c_y;
    assign coord[6] = query.seg_d_x;
    assign coord[7] = query.seg_d_y;
    assign coord[8] = query.seg_e_x;
    assign coord[9] = query.seg_e_y;

    stc_diff #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_diff (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (query.valid),
        .in_rdy  (query.ready),
        .coord   (coord),
        .out_vld (diff_vld),
        .out_rdy (diff_rdy),
        .diff    (diff)
    );

    stc_mult #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (diff_vld),
        .in_rdy  (diff_rdy),
        .diff    (diff),
        .out_vld (prod_vld),
        .out_rdy (prod_rdy),
        .prod    (prod)
    );

    stc_sum #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (prod_vld),
        .in_rdy  (prod_rdy),
        .prod    (prod),
        .out_vld (sum_vld),
        .out_rdy (sum_rdy),
        .sum     (sum)
    );

    stc_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sum_vld),
        .in_rdy   (sum_rdy),
        .sum      (sum),
        .out_vld  (flag_vld),
        .out_rdy  (flag_rdy),
        .edge_hit (edge_hit),
        .pt_hit   (pt_hit)
    );

    // edge crossings take priority over endpoint containment
    always_comb
    begin
        priority if (|edge_hit)
        begin
            kind_next = stc_pkg::KIND_CROSS;
        end
        else if (|pt_hit)
        begin
            kind_next = stc_pkg::KIND_INSIDE;
        end
        else
        begin
            kind_next = stc_pkg::KIND_NONE;
        end
    end

    assign touches_next = (kind_next != stc_pkg::KIND_NONE);

    // result register
    assign flag_rdy = !vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (flag_rdy)
        begin
            vld_reg <= flag_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_rdy && flag_vld)
        begin
            touches_reg <= touches_next;
            kind_reg    <= kind_next;
        end
    end

    assign result.valid    = vld_reg;
    assign result.touches  = touches_reg;
    assign result.hit_kind = kind_reg;

    // touches agrees with the reported kind
    a_touches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.touches == (result.hit_kind != stc_pkg::KIND_NONE)))
        else $error("touches disagrees with hit_kind");

    // unused code never leaves the pipeline
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.hit_kind <= stc_pkg::KIND_INSIDE))
        else $error("illegal hit_kind");

    // a free result side lets every stage advance, so queries are never held
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (!result.valid || result.ready) |-> query.ready)
        else $error("query stalled with free result side");

endmodule
